// ----- rtl/core/spr_pkg.sv -----
// Shared constants and register codes for the speed PI regulator.
`default_nettype none

package spr_pkg;

	localparam int STATE_W         = 23;
	localparam int GAIN_FRAC       = 8;
	localparam int KEEP_ONE        = 256;
	localparam int OUT_W           = 21;
	localparam int TARGET_W        = 14;
	localparam int KEEP_W          = 9;
	localparam int GAIN_W          = 16;
	localparam int LIMIT_W         = 16;
	localparam int CFG_ADDR_W      = 5;
	localparam int CFG_DATA_W      = 32;
	localparam int COUNT_WIDTH_DEF = 13;
	localparam int FRAC_BITS_DEF   = 8;

	localparam logic [TARGET_W-1:0] TARGET_RST = 14'd0;
	localparam logic [KEEP_W-1:0]   KEEP_RST   = 9'd179;
	localparam logic [GAIN_W-1:0]   PROP_RST   = 16'd18688;
	localparam logic [GAIN_W-1:0]   INTEG_RST  = 16'd80;
	localparam logic [LIMIT_W-1:0]  LIMIT_RST  = 16'd10000;

	typedef enum logic [2:0] {
		REG_TARGET = 3'd0,
		REG_KEEP   = 3'd1,
		REG_PROP   = 3'd2,
		REG_INTEG  = 3'd3,
		REG_LIMIT  = 3'd4
	} reg_idx_t;

endpackage

`default_nettype wire

// ----- rtl/core/speed_pi_regulator.sv -----
// Speed PI regulator: low-pass on speed error, clamped integral, shared multiplier.
//
//  channel | direction | handshake            | payload
//  in      | input     | in_valid / in_ready  | left_count, right_count
//  out     | output    | out_valid / out_ready| drive_value
//  cfg     | APB       | psel/penable/pready  | paddr, pwdata, prdata
//
// A transaction is accepted, then runs seven steps of a sequencer
// around one 17 x N multiplier and an accumulator (two filter products, round,
// integrate, two output products, output). in_ready is low during those steps.
// Reset loads the register defaults and clears the filter and integral state.
// A result waiting in the output register stalls only the final step; the next
// transaction is taken while it waits.
`default_nettype none

module speed_pi_regulator
	import spr_pkg::*;
#(
	parameter int COUNT_WIDTH = COUNT_WIDTH_DEF,
	parameter int FRAC_BITS   = FRAC_BITS_DEF
) (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          in_valid,
	output logic                               in_ready,
	input  wire logic signed [COUNT_WIDTH-1:0] left_count,
	input  wire logic signed [COUNT_WIDTH-1:0] right_count,
	output logic                               out_valid,
	input  wire logic                          out_ready,
	output logic signed [OUT_W-1:0]            drive_value,
	input  wire logic                          psel,
	input  wire logic                          penable,
	input  wire logic                          pwrite,
	input  wire logic [CFG_ADDR_W-1:0]         paddr,
	input  wire logic [CFG_DATA_W-1:0]         pwdata,
	output logic [CFG_DATA_W-1:0]              prdata,
	output logic                               pready
);

	localparam int SUM_W  = COUNT_WIDTH + 1;
	localparam int ERR_W  = ((SUM_W > TARGET_W) ? SUM_W : TARGET_W) + 1;
	localparam int BW     = (ERR_W > STATE_W) ? ERR_W : STATE_W;
	localparam int AW     = GAIN_W + 1;
	localparam int PW     = AW + BW;
	localparam int ACC_W  = PW + FRAC_BITS + 1;
	localparam int OUT_SH = GAIN_FRAC + FRAC_BITS;
	localparam int BF_W   = ((LIMIT_W + FRAC_BITS) > STATE_W) ? (LIMIT_W + FRAC_BITS) : STATE_W;

	localparam logic signed [ACC_W-1:0] ST_MAX_A  = ACC_W'((2 ** (STATE_W - 1)) - 1);
	localparam logic signed [ACC_W-1:0] ST_MIN_A  = -ACC_W'(2 ** (STATE_W - 1));
	localparam logic signed [ACC_W-1:0] OUT_MAX_A = ACC_W'((2 ** (OUT_W - 1)) - 1);
	localparam logic signed [ACC_W-1:0] OUT_MIN_A = -ACC_W'(2 ** (OUT_W - 1));
	localparam logic signed [ACC_W-1:0] RND_A     = ACC_W'(2 ** (GAIN_FRAC - 1));
	localparam logic signed [ACC_W-1:0] TRUNC_A   = ACC_W'((2 ** OUT_SH) - 1);
	localparam logic signed [ACC_W-1:0] ZERO_A    = ACC_W'(0);
	localparam logic [BF_W-1:0]         BOUND_MAX = BF_W'((2 ** (STATE_W - 1)) - 1);

	typedef enum logic [7:0] {
		S_IDLE  = 8'b0000_0001,
		S_MUL1  = 8'b0000_0010,
		S_MUL2  = 8'b0000_0100,
		S_FILT  = 8'b0000_1000,
		S_INTEG = 8'b0001_0000,
		S_MUL3  = 8'b0010_0000,
		S_MUL4  = 8'b0100_0000,
		S_OUT   = 8'b1000_0000
	} state_t;

	state_t                      st_q;
	logic [TARGET_W-1:0]         target_q;
	logic [KEEP_W-1:0]           keep_q;
	logic [GAIN_W-1:0]           prop_q;
	logic [GAIN_W-1:0]           integ_gain_q;
	logic [LIMIT_W-1:0]          limit_q;
	logic signed [STATE_W-1:0]   filt_q;
	logic signed [STATE_W-1:0]   integ_q;
	logic signed [ERR_W-1:0]     err_q;
	logic signed [ACC_W-1:0]     acc_q;
	logic                        out_valid_q;
	logic signed [OUT_W-1:0]     drive_q;

	logic                        cfg_wr;
	logic [KEEP_W-1:0]           keep_eff;
	logic signed [AW-1:0]        mul_a;
	logic signed [BW-1:0]        mul_b;
	logic signed [PW-1:0]        prod;
	logic signed [ACC_W-1:0]     prod_ext;
	logic signed [ACC_W-1:0]     filt_sh;
	logic signed [STATE_W-1:0]   filt_new;
	logic [BF_W-1:0]             bound_full;
	logic signed [STATE_W:0]     bound;
	logic signed [STATE_W:0]     integ_sum;
	logic signed [STATE_W:0]     integ_new;
	logic signed [ACC_W-1:0]     out_sh;
	logic signed [OUT_W-1:0]     drive_new;
	logic                        out_free;

	assign pready    = 1'b1;
	assign cfg_wr    = psel && penable && pwrite && pready;
	assign in_ready  = (st_q == S_IDLE);
	assign out_valid = out_valid_q;
	assign drive_value = drive_q;
	assign out_free  = !out_valid_q || out_ready;

	always_comb begin
		case (reg_idx_t'(paddr[4:2]))
			REG_TARGET: prdata = CFG_DATA_W'(target_q);
			REG_KEEP:   prdata = CFG_DATA_W'(keep_q);
			REG_PROP:   prdata = CFG_DATA_W'(prop_q);
			REG_INTEG:  prdata = CFG_DATA_W'(integ_gain_q);
			REG_LIMIT:  prdata = CFG_DATA_W'(limit_q);
			default:    prdata = '0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			target_q     <= TARGET_RST;
			keep_q       <= KEEP_RST;
			prop_q       <= PROP_RST;
			integ_gain_q <= INTEG_RST;
			limit_q      <= LIMIT_RST;
		end else if (cfg_wr) begin
			case (reg_idx_t'(paddr[4:2]))
				REG_TARGET: target_q     <= pwdata[TARGET_W-1:0];
				REG_KEEP:   keep_q       <= pwdata[KEEP_W-1:0];
				REG_PROP:   prop_q       <= pwdata[GAIN_W-1:0];
				REG_INTEG:  integ_gain_q <= pwdata[GAIN_W-1:0];
				REG_LIMIT:  limit_q      <= pwdata[LIMIT_W-1:0];
				default:    ;
			endcase
		end
	end

	assign keep_eff = (keep_q > KEEP_W'(KEEP_ONE)) ? KEEP_W'(KEEP_ONE) : keep_q;

	always_comb begin
		case (st_q)
			S_MUL1: begin
				mul_a = $signed({{(AW-KEEP_W){1'b0}}, keep_eff});
				mul_b = BW'(filt_q);
			end
			S_MUL2: begin
				mul_a = $signed({{(AW-KEEP_W){1'b0}}, KEEP_W'(KEEP_ONE) - keep_eff});
				mul_b = BW'(err_q);
			end
			S_MUL3: begin
				mul_a = $signed({1'b0, prop_q});
				mul_b = BW'(filt_q);
			end
			S_MUL4: begin
				mul_a = $signed({1'b0, integ_gain_q});
				mul_b = BW'(integ_q);
			end
			default: begin
				mul_a = '0;
				mul_b = '0;
			end
		endcase
	end

	assign prod     = mul_a * mul_b;
	assign prod_ext = ACC_W'(prod);

	always_comb begin
		filt_sh = (acc_q + RND_A) >>> GAIN_FRAC;
		if (filt_sh > ST_MAX_A) begin
			filt_new = STATE_W'(ST_MAX_A);
		end else if (filt_sh < ST_MIN_A) begin
			filt_new = STATE_W'(ST_MIN_A);
		end else begin
			filt_new = filt_sh[STATE_W-1:0];
		end
	end

	always_comb begin
		bound_full = BF_W'(limit_q) << FRAC_BITS;
		if (bound_full > BOUND_MAX) begin
			bound = (STATE_W+1)'(BOUND_MAX);
		end else begin
			bound = $signed({1'b0, bound_full[STATE_W-1:0]});
		end
		integ_sum = (STATE_W+1)'(integ_q) + (STATE_W+1)'(filt_q);
		if (integ_sum > bound) begin
			integ_new = bound;
		end else if (integ_sum < -bound) begin
			integ_new = -bound;
		end else begin
			integ_new = integ_sum;
		end
	end

	always_comb begin
		out_sh = (acc_q + (acc_q[ACC_W-1] ? TRUNC_A : ZERO_A)) >>> OUT_SH;
		if (out_sh > OUT_MAX_A) begin
			drive_new = OUT_W'(OUT_MAX_A);
		end else if (out_sh < OUT_MIN_A) begin
			drive_new = OUT_W'(OUT_MIN_A);
		end else begin
			drive_new = out_sh[OUT_W-1:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q        <= S_IDLE;
			filt_q      <= '0;
			integ_q     <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (st_q == S_OUT && out_free) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
			case (st_q)
				S_IDLE: begin
					if (in_valid) begin
						st_q <= S_MUL1;
					end
				end
				S_MUL1:  st_q <= S_MUL2;
				S_MUL2:  st_q <= S_FILT;
				S_FILT: begin
					filt_q <= filt_new;
					st_q   <= S_INTEG;
				end
				S_INTEG: begin
					integ_q <= integ_new[STATE_W-1:0];
					st_q    <= S_MUL3;
				end
				S_MUL3:  st_q <= S_MUL4;
				S_MUL4:  st_q <= S_OUT;
				S_OUT: begin
					if (out_free) begin
						st_q <= S_IDLE;
					end
				end
				default: st_q <= S_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			err_q <= ERR_W'(left_count) + ERR_W'(right_count) - ERR_W'($signed(target_q));
		end
		case (st_q)
			S_MUL1:  acc_q <= prod_ext;
			S_MUL2:  acc_q <= acc_q + (prod_ext <<< FRAC_BITS);
			S_MUL3:  acc_q <= prod_ext;
			S_MUL4:  acc_q <= acc_q + prod_ext;
			default: ;
		endcase
		if (st_q == S_OUT && out_free) begin
			drive_q <= drive_new;
		end
	end

	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> !in_ready)
		else $error("input taken while a transaction is in progress");

	a_result_latency: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready && !out_valid |-> ##8 out_valid)
		else $error("result not presented eight cycles after acceptance");

	a_out_only_from_last_step: assert property (@(posedge clk) disable iff (!arst_n)
		!out_valid ##1 out_valid |-> $past(st_q) == S_OUT)
		else $error("result raised outside the output step");

endmodule

`default_nettype wire
